// File: design/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  // fixed point word and iteration counter widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned StepW  = 31;
  localparam int unsigned CountW = 11;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [2:0] REG_STEP_REAL   = 3'd2;
  localparam logic [2:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

  // reset values of the registers
  localparam logic [WordW-1:0]  ORIGIN_RESET = 32'hE000_0000;
  localparam logic [StepW-1:0]  STEP_RESET   = 31'h0010_0000;
  localparam logic [CountW-1:0] LIMIT_RESET  = 11'd256;

  // one pixel in flight around the ring
  typedef struct packed {
    logic              valid;
    logic [WordW-1:0]  zr;
    logic [WordW-1:0]  zi;
    logic [WordW-1:0]  cr;
    logic [WordW-1:0]  ci;
    logic [CountW-1:0] count;
  } tok_t;

  // finished pixel leaving a cell
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] count;
  } res_t;

  // clamp to the signed 32-bit range
  function automatic logic [WordW-1:0] sat32(input logic signed [63:0] v);
    logic [WordW-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[WordW-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time engine, Q4.28 fixed point.
// Input channel (in_valid_i / in_ready_o) carries one pixel: column_i, row_i.
// Output channel (out_valid_o / out_ready_i) carries iterations_o, the number
// of iterations until |z|^2 reached 4 or the count reached iteration_limit.
// Registers sit on an APB-style port: origin_real 0x00, origin_imag 0x04,
// step_real 0x08, step_imag 0x0c, iteration_limit 0x10. Write them while idle.
// One pixel is worked on at a time. After its transfer the point c is formed
// in the MUL and INJ states, then the pixel circles a ring of iteration cells,
// one iteration per cell (a multiply stage and an update stage in each cell),
// until a cell finds it finished and its count is registered into the output
// register.
// The next input transfer is taken as soon as the result sits in the output
// register.
// If the receiver stalls while the next pixel is still iterating,
// the whole ring freezes until the waiting result is transferred.
// Reset empties the ring and the output register and loads the default view:
// origin -2.0 - 2.0i, step 1/256, limit 256.
module mandelbrot_escape_time #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned NUM_CELLS  = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // pixel input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [COORD_BITS-1:0]      column_i,
  input  logic [COORD_BITS-1:0]      row_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mbe_pkg::CountW-1:0] iterations_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned ProdW = COORD_BITS + mbe_pkg::StepW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_INJ  = 4'b0100,
    ST_RUN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [mbe_pkg::WordW-1:0]  origin_real_q, origin_imag_q;
  logic [mbe_pkg::StepW-1:0]  step_real_q, step_imag_q;
  logic [mbe_pkg::CountW-1:0] limit_q;

  logic [COORD_BITS-1:0]      col_q, row_q;
  logic [ProdW-1:0]           prod_r_q, prod_i_q;
  logic                       out_valid_q;
  logic [mbe_pkg::CountW-1:0] iter_q;

  logic                       cfg_wr;
  logic                       en;
  logic                       any_done;
  logic [mbe_pkg::CountW-1:0] done_count;
  mbe_pkg::tok_t              inj_tok;
  mbe_pkg::tok_t              cell_in  [NUM_CELLS];
  mbe_pkg::tok_t              cell_out [NUM_CELLS];
  mbe_pkg::res_t              cell_res [NUM_CELLS];

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q <= mbe_pkg::ORIGIN_RESET;
      origin_imag_q <= mbe_pkg::ORIGIN_RESET;
      step_real_q   <= mbe_pkg::STEP_RESET;
      step_imag_q   <= mbe_pkg::STEP_RESET;
      limit_q       <= mbe_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mbe_pkg::REG_ORIGIN_REAL: origin_real_q <= pwdata;
        mbe_pkg::REG_ORIGIN_IMAG: origin_imag_q <= pwdata;
        mbe_pkg::REG_STEP_REAL:   step_real_q   <= pwdata[mbe_pkg::StepW-1:0];
        mbe_pkg::REG_STEP_IMAG:   step_imag_q   <= pwdata[mbe_pkg::StepW-1:0];
        mbe_pkg::REG_ITER_LIMIT:  limit_q       <= pwdata[mbe_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      mbe_pkg::REG_ORIGIN_REAL: prdata = origin_real_q;
      mbe_pkg::REG_ORIGIN_IMAG: prdata = origin_imag_q;
      mbe_pkg::REG_STEP_REAL:   prdata = {1'b0, step_real_q};
      mbe_pkg::REG_STEP_IMAG:   prdata = {1'b0, step_imag_q};
      mbe_pkg::REG_ITER_LIMIT:  prdata = {21'b0, limit_q};
      default:                  prdata = '0;
    endcase
  end

  // ring advances unless a finished result is stuck in the output register
  assign en = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_INJ;
      ST_INJ:  if (en) state_d = ST_RUN;
      ST_RUN:  if (en && any_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // pixel capture and offset products
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (state_q == ST_MUL) begin
      prod_r_q <= col_q * step_real_q;
      prod_i_q <= row_q * step_imag_q;
    end
  end

  // starting token: z = 0, c = origin + offset
  always_comb begin
    inj_tok.valid = 1'b1;
    inj_tok.zr    = '0;
    inj_tok.zi    = '0;
    inj_tok.cr    = mbe_pkg::sat32($signed({{32{origin_real_q[31]}}, origin_real_q})
                                   + $signed({{(64 - ProdW){1'b0}}, prod_r_q}));
    inj_tok.ci    = mbe_pkg::sat32($signed({{32{origin_imag_q[31]}}, origin_imag_q})
                                   + $signed({{(64 - ProdW){1'b0}}, prod_i_q}));
    inj_tok.count = '0;
  end

  // ring of iteration cells
  assign cell_in[0] = (state_q == ST_INJ) ? inj_tok : cell_out[NUM_CELLS-1];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    mbe_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .limit_i(limit_q),
      .tok_i  (cell_in[k]),
      .tok_o  (cell_out[k]),
      .res_o  (cell_res[k])
    );
  end

  // collect the finished pixel from whichever cell holds it
  always_comb begin
    any_done   = 1'b0;
    done_count = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      any_done   = any_done | cell_res[k].valid;
      done_count = done_count | (cell_res[k].valid ? cell_res[k].count : '0);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && any_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && any_done) begin
      iter_q <= done_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign iterations_o = iter_q;

endmodule

// File: design/mbe_cell.sv
`timescale 1ns / 1ps

module mbe_cell #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [mbe_pkg::CountW-1:0] limit_i,
  input  mbe_pkg::tok_t              tok_i,
  output mbe_pkg::tok_t              tok_o,
  output mbe_pkg::res_t              res_o
);

  localparam logic [mbe_pkg::WordW:0] Four = 33'(1) << (FRAC_BITS + 2);

  logic signed [mbe_pkg::WordW-1:0] zr_s, zi_s;
  logic signed [63:0]               p_rr_d, p_ii_d, p_ri_d;
  logic signed [63:0]               p_rr_q, p_ii_q, p_ri_q;
  logic                             s1_valid_q;
  logic [mbe_pkg::WordW-1:0]        s1_cr_q, s1_ci_q;
  logic [mbe_pkg::CountW-1:0]       s1_count_q;

  logic [mbe_pkg::WordW-1:0]        sr_w, si_w, t_w, nr_w, ni_w;
  logic [mbe_pkg::WordW:0]          mag_w;
  logic                             escape_w, finish_w;
  mbe_pkg::tok_t                    tok_d, tok_q;
  mbe_pkg::res_t                    res_d, res_q;

  // stage one: the two squares and the cross product of z
  assign zr_s   = $signed(tok_i.zr);
  assign zi_s   = $signed(tok_i.zi);
  assign p_rr_d = zr_s * zr_s;
  assign p_ii_d = zi_s * zi_s;
  assign p_ri_d = zr_s * zi_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q     <= p_rr_d;
      p_ii_q     <= p_ii_d;
      p_ri_q     <= p_ri_d;
      s1_cr_q    <= tok_i.cr;
      s1_ci_q    <= tok_i.ci;
      s1_count_q <= tok_i.count;
    end
  end

  // stage two: scale products, escape test, next z
  always_comb begin
    sr_w     = mbe_pkg::sat32(p_rr_q >>> FRAC_BITS);
    si_w     = mbe_pkg::sat32(p_ii_q >>> FRAC_BITS);
    t_w      = mbe_pkg::sat32(p_ri_q >>> (FRAC_BITS - 1));
    mag_w    = {1'b0, sr_w} + {1'b0, si_w};
    escape_w = (mag_w >= Four);
    finish_w = (s1_count_q != '0) && (escape_w || (s1_count_q >= limit_i));
    nr_w     = mbe_pkg::sat32($signed({32'b0, sr_w}) - $signed({32'b0, si_w})
                              + $signed({{32{s1_cr_q[31]}}, s1_cr_q}));
    ni_w     = mbe_pkg::sat32($signed({{32{t_w[31]}}, t_w})
                              + $signed({{32{s1_ci_q[31]}}, s1_ci_q}));

    tok_d.valid = s1_valid_q && !finish_w;
    tok_d.zr    = nr_w;
    tok_d.zi    = ni_w;
    tok_d.cr    = s1_cr_q;
    tok_d.ci    = s1_ci_q;
    tok_d.count = s1_count_q + mbe_pkg::CountW'(1);

    res_d.valid = s1_valid_q && finish_w;
    res_d.count = s1_count_q;
  end

  // hand the pixel to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      res_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      res_q <= res_d;
    end
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

endmodule

// File: dv/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;

  localparam int unsigned CoordW      = 12;
  localparam int          FracBits    = 28;
  localparam int unsigned WordW       = mbe_pkg::WordW;
  localparam int unsigned StepW       = mbe_pkg::StepW;
  localparam int unsigned CountW      = mbe_pkg::CountW;
  localparam longint      Four        = 64'sd4 <<< FracBits;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxCycles   = 2_000_000;

  // register indexes that decode to nothing
  localparam logic [2:0] RegSpareFirst = 3'd5;
  localparam logic [2:0] RegSpareLast  = 3'd7;

  typedef struct packed {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } pixel_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CoordW-1:0] column_i    = '0;
  logic [CoordW-1:0] row_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CountW-1:0] iterations_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [4:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor copy of the view registers
  logic signed [WordW-1:0] origin_re_q;
  logic signed [WordW-1:0] origin_im_q;
  logic [StepW-1:0]        step_re_q;
  logic [StepW-1:0]        step_im_q;
  logic [CountW-1:0]       limit_q;

  pixel_t            pixels_waiting[$];
  logic [CountW-1:0] iters_due[$];
  int unsigned       pixels_queued = 0;
  int unsigned       pixels_taken  = 0;
  int unsigned       send_gap      = 0;
  int unsigned       recv_stall    = 0;
  int unsigned       hold_left     = 0;
  int unsigned       holds_asked   = 0;
  int unsigned       holds_served  = 0;
  int unsigned       cycle_count   = 0;
  int unsigned       fail_count    = 0;
  bit                no_idle       = 1'b0;

  mandelbrot_escape_time #(
    .COORD_BITS(CoordW),
    .FRAC_BITS (FracBits)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .iterations_o(iterations_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  // clamp to the signed 32-bit range
  function automatic longint clamp_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // escape-time iteration count for one pixel under the current view
  function automatic logic [CountW-1:0] escape_count(input logic [CoordW-1:0] col,
                                                     input logic [CoordW-1:0] row);
    longint      cr, ci, zr, zi, sr, si, nr, ni;
    int unsigned n;
    cr = clamp_word(longint'(origin_re_q) + longint'(col) * longint'(step_re_q));
    ci = clamp_word(longint'(origin_im_q) + longint'(row) * longint'(step_im_q));
    zr = 0;
    zi = 0;
    sr = 0;
    si = 0;
    n  = 0;
    do begin
      nr = clamp_word(sr - si + cr);
      // 2*zr*zi folded into a shift one short of the fraction width
      ni = clamp_word(clamp_word((zr * zi) >>> (FracBits - 1)) + ci);
      zr = nr;
      zi = ni;
      sr = clamp_word((zr * zr) >>> FracBits);
      si = clamp_word((zi * zi) >>> FracBits);
      n++;
    end while ((sr + si < Four) && (n < limit_q));
    return CountW'(n);
  endfunction

  function automatic int unsigned pick_wait();
    if (no_idle) return 0;
    return $urandom_range(14, 0);
  endfunction

  function automatic logic [31:0] to_q28(input real v);
    return $rtoi(v * 268435456.0);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic add_pixel(input int unsigned col, input int unsigned row);
    pixel_t p;
    p.column = col[CoordW-1:0];
    p.row    = row[CoordW-1:0];
    pixels_waiting.push_back(p);
    pixels_queued++;
  endtask

  task automatic add_random_pixels(input int unsigned count);
    for (int unsigned j = 0; j < count; j++) begin
      add_pixel($urandom_range((1 << CoordW) - 1, 0), $urandom_range((1 << CoordW) - 1, 0));
    end
  endtask

  // setup then access phase, register written on the access edge
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mbe_pkg::REG_ORIGIN_REAL: origin_re_q = data;
      mbe_pkg::REG_ORIGIN_IMAG: origin_im_q = data;
      mbe_pkg::REG_STEP_REAL:   step_re_q   = data[StepW-1:0];
      mbe_pkg::REG_STEP_IMAG:   step_im_q   = data[StepW-1:0];
      mbe_pkg::REG_ITER_LIMIT:  limit_q     = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [31:0] ore, input logic [31:0] oim,
                          input logic [31:0] sre, input logic [31:0] sim,
                          input logic [31:0] lim);
    cfg_write(mbe_pkg::REG_ORIGIN_REAL, ore);
    cfg_write(mbe_pkg::REG_ORIGIN_IMAG, oim);
    cfg_write(mbe_pkg::REG_STEP_REAL, sre);
    cfg_write(mbe_pkg::REG_STEP_IMAG, sim);
    cfg_write(mbe_pkg::REG_ITER_LIMIT, lim);
  endtask

  // every pixel transferred in and every result transferred out
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || iters_due.size() != 0) @(posedge clk_i);
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      column_i     <= '0;
      row_i        <= '0;
      send_gap     <= 0;
      pixels_taken <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        iters_due.push_back(escape_count(column_i, row_i));
        pixels_taken <= pixels_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pixels_waiting.size() != 0) begin
          nxt = pixels_waiting.pop_front();
          in_valid_i <= 1'b1;
          column_i   <= nxt.column;
          row_i      <= nxt.row;
          send_gap   <= pick_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned       wait_next;
    logic [CountW-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      wait_next = recv_stall;
      if (out_valid_o && out_ready_i) begin
        if (iters_due.size() == 0) begin
          flag_error($sformatf("result %0d with no pixel outstanding", iterations_o));
        end else begin
          want = iters_due.pop_front();
          if (iterations_o !== want) begin
            flag_error($sformatf("iterations got %0d, want %0d", iterations_o, want));
          end
        end
        wait_next = pick_wait();
      end
      if (wait_next != 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= wait_next - 1;
      end else begin
        out_ready_i <= (hold_left == 0);
        recv_stall  <= 0;
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  always @(posedge clk_i or negedge rst_ni) begin : hold_counter
    if (!rst_ni) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HoldCycles;
      holds_served <= holds_served + 1;
    end
  end

  // run limit
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == MaxCycles) begin
      $display("mandelbrot_escape_time_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int k;
    origin_re_q = mbe_pkg::ORIGIN_RESET;
    origin_im_q = mbe_pkg::ORIGIN_RESET;
    step_re_q   = mbe_pkg::STEP_RESET;
    step_im_q   = mbe_pkg::STEP_RESET;
    limit_q     = mbe_pkg::LIMIT_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view: corners, origin, points on the real line and axis
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(512, 512);    // c = 0, never escapes
    add_pixel(384, 512);    // c = -0.5
    add_pixel(256, 512);    // c = -1, period two
    add_pixel(0, 512);      // c = -2, |z|^2 exactly 4
    add_pixel(1024, 512);   // c = 2
    add_pixel(576, 512);    // cusp at 0.25
    add_pixel(577, 512);    // just past the cusp, slow escape
    add_pixel(512, 768);    // c = i
    add_pixel(512, 256);    // c = -i
    add_pixel(448, 576);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(12'h555, 12'hAAA);
    for (i = 0; i < 120; i++) begin
      if (i % 2 == 0) add_pixel($urandom_range(1023, 0), $urandom_range(1023, 0));
      else add_random_pixels(1);
    end
    wait_idle();

    // whole set across the frame, receiver held off once
    set_view(to_q28(-2.25), to_q28(-1.5), 32'd196608, 32'd196608, 32'd64);
    add_random_pixels(300);
    holds_asked <= holds_asked + 1;
    wait_idle();

    // saturated coordinates, widest step written with the spare bit set, limit zero
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    for (i = RegSpareFirst; i <= RegSpareLast; i++) cfg_write(i[2:0], $urandom());
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_random_pixels(13);
    wait_idle();

    // most negative real and most positive imaginary origin, zero step
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd3);
    add_pixel(4095, 0);
    add_random_pixels(14);
    wait_idle();

    // limit field written all ones, deep points near the main cardioid
    set_view(to_q28(-0.8), to_q28(-0.2), 32'd26214, 32'd26214, 32'hFFFF_FFFF);
    add_random_pixels(8);
    wait_idle();

    set_view(to_q28(-0.2), to_q28(0.6), 32'd19660, 32'd19660, 32'd1024);
    add_random_pixels(10);
    wait_idle();

    // single iteration, back to back
    no_idle <= 1'b1;
    set_view($urandom_range(32'h7FFF_FFFF, 0) - 32'h4000_0000,
             $urandom_range(32'h7FFF_FFFF, 0) - 32'h4000_0000,
             $urandom_range(1 << 20, 0), $urandom_range(1 << 20, 0), 32'd1);
    add_random_pixels(150);
    wait_idle();
    no_idle <= 1'b0;

    // random views around the set, the last with origins and steps fully random
    for (k = 0; k < 4; k++) begin
      if (k == 3) begin
        set_view($urandom(), $urandom(), $urandom(), $urandom(), 32'd40);
      end else begin
        set_view($urandom_range(32'd805306368, 0) + to_q28(-2.5),
                 $urandom_range(32'd805306368, 0) + to_q28(-1.5),
                 $urandom_range(1 << 18, 0), $urandom_range(1 << 18, 0),
                 $urandom_range(128, 2));
      end
      no_idle <= (k == 1);
      add_random_pixels(100);
      if (k == 2) holds_asked <= holds_asked + 1;
      wait_idle();
    end
    no_idle <= 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("mandelbrot_escape_time_tb OK");
    else $display("mandelbrot_escape_time_tb NOT OK");
    $finish;
  end

endmodule
